[hdl/multi_window_request_throttle_core_defines.svh]
// ---------------------------------------------------------------------------
// multi_window_request_throttle_core assertion macros
// Shared property wrappers clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MULTI_WINDOW_REQUEST_THROTTLE_CORE_DEFINES_SVH
`define MULTI_WINDOW_REQUEST_THROTTLE_CORE_DEFINES_SVH

// same-cycle implication
`define MWRT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWRT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mwrt_pkg.sv]
// ---------------------------------------------------------------------------
// mwrt_pkg
// Types, widths and constants of the multi-window request throttle.
// ---------------------------------------------------------------------------
package mwrt_pkg;

  // payload widths
  localparam int unsigned ARRIVAL_W = 32;
  localparam int unsigned TOTAL_W   = 32;

  // default geometry
  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // window sums saturate here
  localparam int unsigned SUM_BITS = 22;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // config register widths
  localparam int unsigned SEC_LIMIT_W   = 16;
  localparam int unsigned WIN_LEN_W     = 7;
  localparam int unsigned SHORT_LIMIT_W = 20;
  localparam int unsigned LONG_LIMIT_W  = 22;
  localparam int unsigned CFG_DATA_W    = 22;
  localparam int unsigned CFG_IDX_W     = 3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT   = 3'd4;

  // config reset values
  localparam logic [SEC_LIMIT_W-1:0]   SECOND_LIMIT_RST = 16'd3;
  localparam logic [WIN_LEN_W-1:0]     SHORT_LEN_RST    = 7'd10;
  localparam logic [SHORT_LIMIT_W-1:0] SHORT_LIMIT_RST  = 20'd20;
  localparam logic [WIN_LEN_W-1:0]     LONG_LEN_RST     = 7'd60;
  localparam logic [LONG_LIMIT_W-1:0]  LONG_LIMIT_RST   = 22'd60;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_SWEEP,
    S_DRAIN,
    S_WRITE
  } mwrt_state_t;

endpackage

[hdl/mwrt_in_if.sv]
// ---------------------------------------------------------------------------
// mwrt_in_if
// Request channel: valid/ready handshake with the arrival time stamp.
// ---------------------------------------------------------------------------
interface mwrt_in_if;
  logic                           valid;
  logic                           ready;
  logic [mwrt_pkg::ARRIVAL_W-1:0] arrival_second;

  modport source (output valid, output arrival_second, input ready);
  modport sink   (input valid, input arrival_second, output ready);
endinterface

[hdl/mwrt_out_if.sv]
// ---------------------------------------------------------------------------
// mwrt_out_if
// Result channel: valid/ready handshake with drop flag and drop total.
// ---------------------------------------------------------------------------
interface mwrt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         drop;
  logic [mwrt_pkg::TOTAL_W-1:0] drops_so_far;

  modport source (output valid, output drop, output drops_so_far, input ready);
  modport sink   (input valid, input drop, input drops_so_far, output ready);
endinterface

[hdl/mwrt_ram.sv]
// ---------------------------------------------------------------------------
// mwrt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mwrt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/multi_window_request_throttle_core.sv]
// ---------------------------------------------------------------------------
// multi_window_request_throttle_core
// Three-window request throttle over a ring of per-second counts in RAM.
// ---------------------------------------------------------------------------
// One request is in flight at a time; a new request is accepted only once the
// previous one has reached its result. Each request sweeps N ring slots
// through the single read port: the larger clamped window length (60 with the
// reset settings), or the number of skipped seconds if that is larger, capped
// at RING_DEPTH. Skipped seconds are zeroed during the same sweep; a jump of
// RING_DEPTH or more seconds wipes the whole ring, and the ring keeps its old
// origin slot then, since only slot positions relative to the newest second
// matter. After reset the block runs a clearing pass over the whole ring
// before it takes its first request; config writes are taken throughout. A
// finished result waits in the output register while the next request is accepted.
// ---------------------------------------------------------------------------
`include "multi_window_request_throttle_core_defines.svh"

module multi_window_request_throttle_core #(
  parameter int unsigned RING_DEPTH = mwrt_pkg::RING_DEPTH_DEF,
  parameter int unsigned COUNT_BITS = mwrt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mwrt_in_if.sink                         in_if,
  mwrt_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [mwrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW    = $clog2(RING_DEPTH);
  localparam int unsigned KW    = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUMW  = COUNT_BITS + KW;
  localparam int unsigned SAT_W = (SUMW > mwrt_pkg::SUM_BITS) ? SUMW : mwrt_pkg::SUM_BITS;
  localparam int unsigned KLW   = (KW > mwrt_pkg::WIN_LEN_W) ? KW : mwrt_pkg::WIN_LEN_W;
  localparam int unsigned CMPW  = (COUNT_BITS > mwrt_pkg::SEC_LIMIT_W) ?
                                  COUNT_BITS : mwrt_pkg::SEC_LIMIT_W;

  // config registers
  logic [mwrt_pkg::SEC_LIMIT_W-1:0]   second_limit_r;
  logic [mwrt_pkg::WIN_LEN_W-1:0]     short_len_r;
  logic [mwrt_pkg::SHORT_LIMIT_W-1:0] short_limit_r;
  logic [mwrt_pkg::WIN_LEN_W-1:0]     long_len_r;
  logic [mwrt_pkg::LONG_LIMIT_W-1:0]  long_limit_r;

  // control state
  mwrt_pkg::mwrt_state_t          state_r, state_nxt;
  logic [AW-1:0]                  clr_idx_r, clr_idx_nxt;
  logic [mwrt_pkg::ARRIVAL_W-1:0] newest_r, newest_nxt;
  logic [AW-1:0]                  newest_slot_r, newest_slot_nxt;
  logic [mwrt_pkg::TOTAL_W-1:0]   drop_total_r, drop_total_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           p_valid_r, p_valid_nxt;

  // datapath state
  logic [mwrt_pkg::ARRIVAL_W-1:0] t_r, t_nxt;
  logic [mwrt_pkg::ARRIVAL_W-1:0] gap_r, gap_nxt;
  logic [KW-1:0]                  n_r, n_nxt;
  logic [KW-1:0]                  k_r, k_nxt;
  logic [AW-1:0]                  ptr_r, ptr_nxt;
  logic [AW-1:0]                  slot_t_r, slot_t_nxt;
  logic [SAT_W-1:0]               short_acc_r, short_acc_nxt;
  logic [SAT_W-1:0]               long_acc_r, long_acc_nxt;
  logic [COUNT_BITS-1:0]          own_r, own_nxt;
  logic                           p_first_r, p_first_nxt;
  logic                           p_fresh_r, p_fresh_nxt;
  logic                           p_short_r, p_short_nxt;
  logic                           p_long_r, p_long_nxt;
  logic                           out_drop_r, out_drop_nxt;
  logic [mwrt_pkg::TOTAL_W-1:0]   out_total_r, out_total_nxt;

  // ring memory port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // helpers
  logic [KW-1:0]                  short_len_c, long_len_c, max_len_c, gap_c;
  logic                           gap_big;
  logic [AW:0]                    slot_sum, slot_near;
  logic [AW-1:0]                  slot_sel;
  logic [AW-1:0]                  ptr_dec;
  logic [mwrt_pkg::ARRIVAL_W-1:0] t_in;
  logic                           fresh;
  logic [COUNT_BITS-1:0]          rd_val, own_inc;
  logic                           drop_c;

  // clamp a window length to 1..RING_DEPTH
  function automatic logic [KW-1:0] clamp_len(input logic [mwrt_pkg::WIN_LEN_W-1:0] len);
    logic [KLW-1:0] e;
    e = KLW'(len);
    if (e == '0) begin
      clamp_len = KW'(1);
    end else if (e > KLW'(RING_DEPTH)) begin
      clamp_len = KW'(RING_DEPTH);
    end else begin
      clamp_len = e[KW-1:0];
    end
  endfunction

  // saturate an exact sum to the window sum range
  function automatic logic [mwrt_pkg::SUM_BITS-1:0] sat_sum(input logic [SAT_W-1:0] s);
    if (s > SAT_W'(mwrt_pkg::SUM_MAX)) begin
      sat_sum = mwrt_pkg::SUM_MAX;
    end else begin
      sat_sum = s[mwrt_pkg::SUM_BITS-1:0];
    end
  endfunction

  mwrt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_limit_r <= mwrt_pkg::SECOND_LIMIT_RST;
      short_len_r    <= mwrt_pkg::SHORT_LEN_RST;
      short_limit_r  <= mwrt_pkg::SHORT_LIMIT_RST;
      long_len_r     <= mwrt_pkg::LONG_LEN_RST;
      long_limit_r   <= mwrt_pkg::LONG_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mwrt_pkg::CFG_SECOND_LIMIT: second_limit_r <= cfg_wdata[mwrt_pkg::SEC_LIMIT_W-1:0];
        mwrt_pkg::CFG_SHORT_LEN:    short_len_r    <= cfg_wdata[mwrt_pkg::WIN_LEN_W-1:0];
        mwrt_pkg::CFG_SHORT_LIMIT:  short_limit_r  <= cfg_wdata[mwrt_pkg::SHORT_LIMIT_W-1:0];
        mwrt_pkg::CFG_LONG_LEN:     long_len_r     <= cfg_wdata[mwrt_pkg::WIN_LEN_W-1:0];
        mwrt_pkg::CFG_LONG_LIMIT:   long_limit_r   <= cfg_wdata[mwrt_pkg::LONG_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // window lengths and gap derived values
  always_comb begin
    short_len_c = clamp_len(short_len_r);
    long_len_c  = clamp_len(long_len_r);
    max_len_c   = (short_len_c > long_len_c) ? short_len_c : long_len_c;
    gap_big     = gap_r >= mwrt_pkg::ARRIVAL_W'(RING_DEPTH);
    gap_c       = gap_big ? KW'(RING_DEPTH) : gap_r[KW-1:0];
  end

  // slot arithmetic: near advance, ring walk
  always_comb begin
    slot_sum  = {1'b0, newest_slot_r} + {1'b0, gap_r[AW-1:0]};
    slot_near = (slot_sum >= (AW+1)'(RING_DEPTH)) ? slot_sum - (AW+1)'(RING_DEPTH) : slot_sum;
    // a wiped ring keeps its origin slot
    slot_sel  = gap_big ? newest_slot_r : slot_near[AW-1:0];
    ptr_dec   = (ptr_r == '0) ? AW'(RING_DEPTH - 1) : ptr_r - AW'(1);
  end

  // decision and count update
  always_comb begin
    t_in    = (in_if.arrival_second < newest_r) ? newest_r : in_if.arrival_second;
    fresh   = k_r < gap_c;
    rd_val  = p_fresh_r ? '0 : ram_rdata;
    own_inc = (own_r == '1) ? own_r : own_r + COUNT_BITS'(1);
    drop_c  = (CMPW'(own_r) >= CMPW'(second_limit_r)) ||
              (sat_sum(short_acc_r) >= mwrt_pkg::SUM_BITS'(short_limit_r)) ||
              (sat_sum(long_acc_r) >= long_limit_r);
  end

  // sequencer: next state and datapath
  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    newest_nxt      = newest_r;
    newest_slot_nxt = newest_slot_r;
    drop_total_nxt  = drop_total_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    p_valid_nxt     = 1'b0;
    t_nxt           = t_r;
    gap_nxt         = gap_r;
    n_nxt           = n_r;
    k_nxt           = k_r;
    ptr_nxt         = ptr_r;
    slot_t_nxt      = slot_t_r;
    short_acc_nxt   = short_acc_r;
    long_acc_nxt    = long_acc_r;
    own_nxt         = own_r;
    p_first_nxt     = p_first_r;
    p_fresh_nxt     = p_fresh_r;
    p_short_nxt     = p_short_r;
    p_long_nxt      = p_long_r;
    out_drop_nxt    = out_drop_r;
    out_total_nxt   = out_total_r;
    ram_we          = 1'b0;
    ram_waddr       = ptr_r;
    ram_wdata       = '0;
    ram_raddr       = ptr_r;

    case (state_r)
      // zero the ring once after reset
      mwrt_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        if (clr_idx_r == AW'(RING_DEPTH - 1)) begin
          state_nxt = mwrt_pkg::S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      // take a request, clamp its stamp
      mwrt_pkg::S_IDLE: begin
        if (in_if.valid) begin
          t_nxt     = t_in;
          gap_nxt   = t_in - newest_r;
          state_nxt = mwrt_pkg::S_PREP;
        end
      end
      // pick slot and sweep length
      mwrt_pkg::S_PREP: begin
        short_acc_nxt = '0;
        long_acc_nxt  = '0;
        k_nxt         = '0;
        n_nxt         = (gap_c > max_len_c) ? gap_c : max_len_c;
        slot_t_nxt    = slot_sel;
        ptr_nxt       = slot_sel;
        state_nxt     = mwrt_pkg::S_SWEEP;
      end
      // walk back from the request slot, zeroing skipped seconds
      mwrt_pkg::S_SWEEP: begin
        ram_raddr   = ptr_r;
        ram_we      = fresh;
        ram_waddr   = ptr_r;
        p_valid_nxt = 1'b1;
        p_first_nxt = k_r == '0;
        p_fresh_nxt = fresh;
        p_short_nxt = (k_r < short_len_c) && (mwrt_pkg::ARRIVAL_W'(k_r) < t_r);
        p_long_nxt  = (k_r < long_len_c) && (mwrt_pkg::ARRIVAL_W'(k_r) < t_r);
        ptr_nxt     = ptr_dec;
        k_nxt       = k_r + KW'(1);
        if (k_r == n_r - KW'(1)) begin
          state_nxt = mwrt_pkg::S_DRAIN;
        end
      end
      // last read lands
      mwrt_pkg::S_DRAIN: begin
        state_nxt = mwrt_pkg::S_WRITE;
      end
      // count the request and present the result
      mwrt_pkg::S_WRITE: begin
        if (!out_valid_r || out_if.ready) begin
          ram_we          = 1'b1;
          ram_waddr       = slot_t_r;
          ram_wdata       = own_inc;
          if (drop_c && drop_total_r != '1) begin
            drop_total_nxt = drop_total_r + mwrt_pkg::TOTAL_W'(1);
            out_total_nxt  = drop_total_r + mwrt_pkg::TOTAL_W'(1);
          end else begin
            out_total_nxt  = drop_total_r;
          end
          out_drop_nxt    = drop_c;
          out_valid_nxt   = 1'b1;
          newest_nxt      = t_r;
          newest_slot_nxt = slot_t_r;
          state_nxt       = mwrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mwrt_pkg::S_IDLE;
      end
    endcase

    // accumulate returning reads
    if (p_valid_r) begin
      if (p_short_r) begin
        short_acc_nxt = short_acc_r + SAT_W'(rd_val);
      end
      if (p_long_r) begin
        long_acc_nxt = long_acc_r + SAT_W'(rd_val);
      end
      if (p_first_r) begin
        own_nxt = rd_val;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mwrt_pkg::S_CLEAR;
      clr_idx_r     <= '0;
      newest_r      <= '0;
      newest_slot_r <= '0;
      drop_total_r  <= '0;
      out_valid_r   <= 1'b0;
      p_valid_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      newest_r      <= newest_nxt;
      newest_slot_r <= newest_slot_nxt;
      drop_total_r  <= drop_total_nxt;
      out_valid_r   <= out_valid_nxt;
      p_valid_r     <= p_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    gap_r       <= gap_nxt;
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    ptr_r       <= ptr_nxt;
    slot_t_r    <= slot_t_nxt;
    short_acc_r <= short_acc_nxt;
    long_acc_r  <= long_acc_nxt;
    own_r       <= own_nxt;
    p_first_r   <= p_first_nxt;
    p_fresh_r   <= p_fresh_nxt;
    p_short_r   <= p_short_nxt;
    p_long_r    <= p_long_nxt;
    out_drop_r  <= out_drop_nxt;
    out_total_r <= out_total_nxt;
  end

  // ports
  assign in_if.ready         = state_r == mwrt_pkg::S_IDLE;
  assign out_if.valid        = out_valid_r;
  assign out_if.drop         = out_drop_r;
  assign out_if.drops_so_far = out_total_r;

  // checks
  `MWRT_ASSERT_NEXT(a_accept_to_prep, in_if.valid && in_if.ready, state_r == mwrt_pkg::S_PREP, "accepted item did not start preparation")
  `MWRT_ASSERT_IMP(a_sweep_writes_zero, ram_we && state_r == mwrt_pkg::S_SWEEP, ram_wdata == '0, "sweep wrote a nonzero count")
  `MWRT_ASSERT_IMP(a_newest_monotonic, $past(rst_n), newest_r >= $past(newest_r), "newest second went backward")
  `MWRT_ASSERT_IMP(a_sweep_in_range, state_r == mwrt_pkg::S_SWEEP, k_r < n_r, "sweep index past its length")

endmodule
